@@ src/lfu_pkg.sv @@
// Shared types and constants for the LFU cache table.
// No dependencies; used by the interfaces, the scan unit and the top level.
package lfu_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 31;
    localparam int USE_W       = 32;
    localparam int STAMP_W     = 64;
    localparam int CAP_W       = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [USE_W-1:0]   use_cnt;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // Flags produced by the scan unit after a full pass
    typedef struct packed {
        logic hit;
        logic min_found;
        logic free_found;
    } t_scan_flags;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_DONE   = 4'b1000
    } t_state;

endpackage

@@ src/lfu_req_if.sv @@
// Request channel: valid/ready handshake carrying cmd, key and value.
// Depends on lfu_pkg for field widths.
interface lfu_req_if;
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [lfu_pkg::KEY_W-1:0] key;
    logic [lfu_pkg::VAL_W-1:0] value;

    modport source (output valid, cmd, key, value, input ready);
    modport sink   (input valid, cmd, key, value, output ready);
endinterface

@@ src/lfu_rsp_if.sv @@
// Response channel: valid/ready handshake carrying hit and read_value.
// Depends on lfu_pkg for field widths.
interface lfu_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic [lfu_pkg::VAL_W-1:0] read_value;

    modport source (output valid, hit, read_value, input ready);
    modport sink   (input valid, hit, read_value, output ready);
endinterface

@@ src/lfu_cfg_if.sv @@
// Configuration write channel: valid/ready handshake carrying cap_limit data.
// Depends on lfu_pkg for the register width.
interface lfu_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [lfu_pkg::CAP_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ src/lfu_scan.sv @@
// Scan accumulator: walks the entries one per cycle and tracks the key match,
// the LFU/LRU victim and the lowest free slot. Depends on lfu_pkg.
module lfu_scan #(
    parameter int IDX_W = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_vld,
    input  logic [IDX_W-1:0]             i_idx,
    input  logic                         i_ent_valid,
    input  lfu_pkg::t_entry              i_ent,
    input  logic [lfu_pkg::KEY_W-1:0]    i_key,
    output lfu_pkg::t_scan_flags         o_flags,
    output logic [IDX_W-1:0]             o_hit_idx,
    output lfu_pkg::t_entry              o_hit_ent,
    output logic [IDX_W-1:0]             o_min_idx,
    output logic [IDX_W-1:0]             o_free_idx
);

    lfu_pkg::t_scan_flags r_flags, n_flags;
    logic [IDX_W-1:0]     r_hit_idx, r_min_idx, r_free_idx;
    lfu_pkg::t_entry      r_hit_ent;
    logic [lfu_pkg::USE_W-1:0]   r_min_cnt;
    logic [lfu_pkg::STAMP_W-1:0] r_min_stamp;
    logic take_hit, take_min, take_free;

    // Decide which trackers this entry updates
    always_comb begin
        take_hit  = i_vld && i_ent_valid && !r_flags.hit && (i_ent.key == i_key);
        take_min  = i_vld && i_ent_valid &&
                    (!r_flags.min_found ||
                     ({i_ent.use_cnt, i_ent.stamp} < {r_min_cnt, r_min_stamp}));
        take_free = i_vld && !i_ent_valid && !r_flags.free_found;
        n_flags = r_flags;
        if (take_hit) begin
            n_flags.hit = 1'b1;
        end
        if (take_min) begin
            n_flags.min_found = 1'b1;
        end
        if (take_free) begin
            n_flags.free_found = 1'b1;
        end
    end

    // Clear flags on start, else accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    // Capture payload of the tracked entries
    always_ff @(posedge i_clk) begin
        if (take_hit) begin
            r_hit_idx <= i_idx;
            r_hit_ent <= i_ent;
        end
        if (take_min) begin
            r_min_idx   <= i_idx;
            r_min_cnt   <= i_ent.use_cnt;
            r_min_stamp <= i_ent.stamp;
        end
        if (take_free) begin
            r_free_idx <= i_idx;
        end
    end

    assign o_flags    = r_flags;
    assign o_hit_idx  = r_hit_idx;
    assign o_hit_ent  = r_hit_ent;
    assign o_min_idx  = r_min_idx;
    assign o_free_idx = r_free_idx;

endmodule

@@ src/lfu_cache_table_core.sv @@
// LFU cache table core: fully associative key/value store with LFU eviction
// and oldest-touch tie-break. Each get or put transaction takes one scan pass
// over the entry memory at one entry per cycle; a put miss that must evict
// repeats the pass once per evicted entry (several evictions follow a lowered
// cap_limit). The single read port of the entry memory sets this pace. A new
// request is accepted while the previous response still waits on the output
// register.
// Depends on lfu_pkg, lfu_req_if, lfu_rsp_if, lfu_cfg_if and lfu_scan.
module lfu_cache_table_core #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lfu_req_if.sink   i_req,
    lfu_rsp_if.source o_rsp,
    lfu_cfg_if.sink   i_cfg
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CW    = (CNT_W > lfu_pkg::CAP_W) ? CNT_W : lfu_pkg::CAP_W;
    localparam logic [CW-1:0]    ENT_C    = CW'(ENTRIES);
    localparam logic [CNT_W-1:0] ENT_N    = CNT_W'(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    lfu_pkg::t_entry r_mem [ENTRIES];
    lfu_pkg::t_entry r_rd_data;
    logic [ENTRIES-1:0] r_valid;

    lfu_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_addr;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;
    logic [CNT_W-1:0] r_occ;
    logic [lfu_pkg::STAMP_W-1:0] r_stamp;
    logic [lfu_pkg::CAP_W-1:0]   r_cap;

    logic                      r_cmd;
    logic [lfu_pkg::KEY_W-1:0] r_key;
    logic [lfu_pkg::VAL_W-1:0] r_val;

    logic                      r_res_hit;
    logic [lfu_pkg::VAL_W-1:0] r_res_val;
    logic                      r_out_vld;
    logic                      r_out_hit;
    logic [lfu_pkg::VAL_W-1:0] r_out_val;

    lfu_pkg::t_scan_flags scan_flags;
    logic [IDX_W-1:0]     hit_idx, min_idx, free_idx;
    lfu_pkg::t_entry      hit_ent, wr_ent;
    logic                 issue, scan_start, scan_last, mem_we;
    logic [IDX_W-1:0]     wr_idx;
    logic [CW-1:0]        cap_eff, cap_ext, occ_ext;
    logic                 need_evict, out_free;
    logic [lfu_pkg::USE_W-1:0] cnt_inc;

    assign i_req.ready = (r_state == lfu_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.read_value = r_out_val;

    // Scan address issue and read-data tracking
    assign issue      = (r_state == lfu_pkg::ST_SCAN) && (r_addr != ENT_N);
    assign scan_last  = r_rd_vld && (r_rd_idx == LAST_IDX);
    assign scan_start = i_req.valid && i_req.ready;

    lfu_scan #(.IDX_W(IDX_W)) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (scan_start || (r_state == lfu_pkg::ST_DECIDE)),
        .i_vld       (r_rd_vld),
        .i_idx       (r_rd_idx),
        .i_ent_valid (r_valid[r_rd_idx]),
        .i_ent       (r_rd_data),
        .i_key       (r_key),
        .o_flags     (scan_flags),
        .o_hit_idx   (hit_idx),
        .o_hit_ent   (hit_ent),
        .o_min_idx   (min_idx),
        .o_free_idx  (free_idx)
    );

    // Capacity bookkeeping
    always_comb begin
        cap_ext    = CW'(r_cap);
        cap_eff    = (cap_ext > ENT_C) ? ENT_C : cap_ext;
        occ_ext    = CW'(r_occ);
        need_evict = (occ_ext >= cap_eff) && (r_occ != '0);
        out_free   = !r_out_vld || o_rsp.ready;
        cnt_inc    = (hit_ent.use_cnt == '1) ? hit_ent.use_cnt : hit_ent.use_cnt + 1'b1;
    end

    // Write-back selection in the decide step
    always_comb begin
        mem_we = 1'b0;
        wr_idx = hit_idx;
        wr_ent = hit_ent;
        if (r_state == lfu_pkg::ST_DECIDE) begin
            if (scan_flags.hit && (r_cmd == lfu_pkg::CMD_GET || r_cap != '0)) begin
                mem_we         = 1'b1;
                wr_ent.use_cnt = cnt_inc;
                wr_ent.stamp   = r_stamp;
                if (r_cmd == lfu_pkg::CMD_PUT) begin
                    wr_ent.value = r_val;
                end
            end else if (!scan_flags.hit && r_cmd == lfu_pkg::CMD_PUT &&
                         r_cap != '0 && !need_evict) begin
                mem_we         = 1'b1;
                wr_idx         = free_idx;
                wr_ent.key     = r_key;
                wr_ent.value   = r_val;
                wr_ent.use_cnt = lfu_pkg::USE_W'(1);
                wr_ent.stamp   = r_stamp;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lfu_pkg::ST_IDLE: begin
                if (scan_start) begin
                    n_state = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN: begin
                if (scan_last) begin
                    n_state = lfu_pkg::ST_DECIDE;
                end
            end
            lfu_pkg::ST_DECIDE: begin
                if (r_cmd == lfu_pkg::CMD_PUT && !scan_flags.hit &&
                    r_cap != '0 && need_evict) begin
                    n_state = lfu_pkg::ST_SCAN;
                end else begin
                    n_state = lfu_pkg::ST_DONE;
                end
            end
            lfu_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = lfu_pkg::ST_IDLE;
                end
            end
            default: n_state = lfu_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lfu_pkg::ST_IDLE;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_valid   <= '0;
            r_occ     <= '0;
            r_stamp   <= '0;
            r_cap     <= lfu_pkg::CAP_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            if (issue) begin
                r_addr <= r_addr + 1'b1;
            end else if (r_state != lfu_pkg::ST_SCAN) begin
                r_addr <= '0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap <= i_cfg.data;
            end
            // Evict the victim, or insert and touch
            if (r_state == lfu_pkg::ST_DECIDE && r_cmd == lfu_pkg::CMD_PUT &&
                !scan_flags.hit && r_cap != '0) begin
                if (need_evict) begin
                    r_valid[min_idx] <= 1'b0;
                    r_occ            <= r_occ - 1'b1;
                end else begin
                    r_valid[free_idx] <= 1'b1;
                    r_occ             <= r_occ + 1'b1;
                end
            end
            if (mem_we) begin
                r_stamp <= r_stamp + 1'b1;
            end
            // Output register: load on finish, drop when taken
            if (r_state == lfu_pkg::ST_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Request capture, result staging and output payload
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr[IDX_W-1:0];
        if (scan_start) begin
            r_cmd <= i_req.cmd;
            r_key <= i_req.key;
            r_val <= i_req.value;
        end
        if (r_state == lfu_pkg::ST_DECIDE) begin
            r_res_hit <= scan_flags.hit;
            r_res_val <= (scan_flags.hit && r_cmd == lfu_pkg::CMD_GET) ?
                         hit_ent.value : '0;
        end
        if (r_state == lfu_pkg::ST_DONE && out_free) begin
            r_out_hit <= r_res_hit;
            r_out_val <= r_res_val;
        end
    end

    // Entry memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= r_mem[r_addr[IDX_W-1:0]];
        end
        if (mem_we) begin
            r_mem[wr_idx] <= wr_ent;
        end
    end

`ifndef SYNTHESIS
    // Occupancy tracks the number of valid entries
    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ == CNT_W'($countones(r_valid)))
        else $error("occupancy does not match valid entries");

    // No write-back while a scan pass reads the memory
    a_no_wr_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && r_state == lfu_pkg::ST_SCAN))
        else $error("memory written during scan");

    // A finished transaction reaches the output register in the next cycle once it is free
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lfu_pkg::ST_DONE && out_free) |=> r_out_vld)
        else $error("result not loaded into output register");
`endif

endmodule

@@ bench/tb_lfu_cache_table_core.sv @@
// Testbench for lfu_cache_table_core: drives get/put transactions and cap_limit writes,
// predicts every response with an LFU table model and checks it field by field.
// Depends on lfu_pkg, lfu_req_if, lfu_rsp_if, lfu_cfg_if and the core RTL.
module tb_lfu_cache_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NENT = 64;
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic                      hit;
        logic [lfu_pkg::VAL_W-1:0] rd;
    } t_resp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    lfu_req_if req_ch ();
    lfu_rsp_if rsp_ch ();
    lfu_cfg_if cfg_ch ();

    lfu_cache_table_core #(.ENTRIES(NENT)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req(req_ch.sink), .o_rsp(rsp_ch.source), .i_cfg(cfg_ch.sink)
    );

    // LFU table model
    logic                        tbl_valid [NENT];
    logic [lfu_pkg::KEY_W-1:0]   tbl_key   [NENT];
    logic [lfu_pkg::VAL_W-1:0]   tbl_val   [NENT];
    logic [lfu_pkg::USE_W-1:0]   tbl_use   [NENT];
    logic [lfu_pkg::STAMP_W-1:0] tbl_stamp [NENT];
    int                          tbl_fill;
    logic [lfu_pkg::STAMP_W-1:0] stamp_now;
    logic [lfu_pkg::CAP_W-1:0]   cap_reg;

    t_resp  expected_rsp[$];
    int     mismatches = 0;
    longint cycles = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_off = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        mismatches++;
        $display("mismatch %0s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    endtask

    function automatic void table_reset();
        for (int i = 0; i < NENT; i++) tbl_valid[i] = 1'b0;
        tbl_fill = 0;
        stamp_now = '0;
        cap_reg = lfu_pkg::CAP_RESET;
    endfunction

    function automatic void evict_lfu();
        int v;
        v = -1;
        for (int i = 0; i < NENT; i++) begin
            if (!tbl_valid[i]) continue;
            if (v < 0 || tbl_use[i] < tbl_use[v] ||
                (tbl_use[i] == tbl_use[v] && tbl_stamp[i] < tbl_stamp[v]))
                v = i;
        end
        if (v >= 0) begin
            tbl_valid[v] = 1'b0;
            if (tbl_fill > 0) tbl_fill--;
        end
    endfunction

    function automatic t_resp predict_lookup(input logic cmd,
                                             input logic [lfu_pkg::KEY_W-1:0] k,
                                             input logic [lfu_pkg::VAL_W-1:0] v);
        t_resp r;
        int idx;
        int cap;
        idx = -1;
        cap = (cap_reg > NENT) ? NENT : int'(cap_reg);
        for (int i = 0; i < NENT; i++)
            if (idx < 0 && tbl_valid[i] && tbl_key[i] == k) idx = i;
        r.hit = (idx >= 0);
        r.rd = '0;
        if (cmd == lfu_pkg::CMD_GET) begin
            if (idx >= 0) begin
                if (tbl_use[idx] != '1) tbl_use[idx]++;
                tbl_stamp[idx] = stamp_now++;
                r.rd = tbl_val[idx];
            end
            return r;
        end
        if (cap == 0) return r;
        if (idx >= 0) begin
            tbl_val[idx] = v;
            if (tbl_use[idx] != '1) tbl_use[idx]++;
            tbl_stamp[idx] = stamp_now++;
            return r;
        end
        while (tbl_fill >= cap && tbl_fill > 0) evict_lfu();
        for (int i = 0; i < NENT; i++) begin
            if (!tbl_valid[i]) begin
                tbl_valid[i] = 1'b1;
                tbl_key[i] = k;
                tbl_val[i] = v;
                tbl_use[i] = lfu_pkg::USE_W'(1);
                tbl_stamp[i] = stamp_now++;
                tbl_fill++;
                break;
            end
        end
        return r;
    endfunction

    // Send one transaction, idling the sender at random beforehand
    task automatic send_item(input logic cmd, input logic [lfu_pkg::KEY_W-1:0] k,
                             input logic [lfu_pkg::VAL_W-1:0] v);
        bit idle_now;
        idle_now = ($urandom_range(99) < send_idle_pct);
        if (idle_now) req_ch.valid <= 1'b0;
        while (idle_now) begin
            @(posedge i_clk);
            idle_now = ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= cmd;
        req_ch.key   <= k;
        req_ch.value <= v;
        do @(posedge i_clk); while (!req_ch.ready);
        expected_rsp.push_back(predict_lookup(cmd, k, v));
    endtask

    // Drop the request and wait until every response is back
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_cap(input logic [lfu_pkg::CAP_W-1:0] c);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= c;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cap_reg = c;
    endtask

    // Mostly reuse a small key range so hits and evictions happen
    function automatic logic [lfu_pkg::KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8) return $urandom();
        if (sel < 12) return (sel & 1) ? '1 : '0;
        return $urandom_range(0, 90);
    endfunction

    task automatic random_items(input int n);
        logic [lfu_pkg::VAL_W-1:0] v;
        for (int i = 0; i < n; i++) begin
            v = ($urandom_range(9) == 0) ? {lfu_pkg::VAL_W{1'b1}} :
                lfu_pkg::VAL_W'($urandom());
            send_item(1'($urandom_range(1)), pick_key(), v);
        end
    endtask

    // Response check; sampled at the edge where the transaction completes
    always @(posedge i_clk) begin
        t_resp want;
        cycles <= cycles + 1;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
                report("unexpected response", 64'(rsp_ch.hit), 64'(0));
            end else begin
                want = expected_rsp.pop_front();
                if (rsp_ch.hit !== want.hit)
                    report("hit", 64'(rsp_ch.hit), 64'(want.hit));
                if (rsp_ch.read_value !== want.rd)
                    report("read_value", 64'(rsp_ch.read_value), 64'(want.rd));
            end
        end
    end

    // Receiver stall process, with a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_lfu_cache_table_core NOT OK");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(lfu_pkg::CMD_GET, 32'h0, '0);
        send_item(lfu_pkg::CMD_PUT, 32'h0, '0);
        send_item(lfu_pkg::CMD_PUT, 32'hFFFF_FFFF, {lfu_pkg::VAL_W{1'b1}});
        send_item(lfu_pkg::CMD_GET, 32'hFFFF_FFFF, '0);
        send_item(lfu_pkg::CMD_GET, 32'h0, 31'h1234);
        send_item(lfu_pkg::CMD_PUT, 32'h0, 31'h5555_5555);
        send_item(lfu_pkg::CMD_GET, 32'h0, '0);
        send_item(lfu_pkg::CMD_GET, 32'hAAAA_AAAA, '0);
        send_item(lfu_pkg::CMD_PUT, 32'h5555_5555, 31'h2AAA_AAAA);
        send_item(lfu_pkg::CMD_GET, 32'h5555_5555, '0);
    endtask

    task automatic test_small_capacity();
        write_cap(7'd2);
        send_item(lfu_pkg::CMD_PUT, 32'd1, 31'd10);   // lowered capacity: several evictions
        send_item(lfu_pkg::CMD_PUT, 32'd2, 31'd20);
        send_item(lfu_pkg::CMD_GET, 32'd1, '0);
        send_item(lfu_pkg::CMD_PUT, 32'd3, 31'd30);   // lowest count leaves
        send_item(lfu_pkg::CMD_GET, 32'd2, '0);
        send_item(lfu_pkg::CMD_PUT, 32'd4, 31'd40);
        send_item(lfu_pkg::CMD_GET, 32'd3, '0);
        send_item(lfu_pkg::CMD_GET, 32'd1, '0);
        random_items(60);
    endtask

    task automatic test_zero_capacity();
        write_cap(7'd0);
        send_item(lfu_pkg::CMD_PUT, 32'd1, 31'd77);   // no change, hit or miss
        send_item(lfu_pkg::CMD_PUT, 32'd999, 31'd1);  // no change
        send_item(lfu_pkg::CMD_GET, 32'd1, '0);
        random_items(40);
    endtask

    task automatic test_capacity_extremes();
        write_cap(7'd127);                   // saturates at table size
        random_items(150);
        write_cap(7'd3);                     // lowered below occupancy
        send_item(lfu_pkg::CMD_PUT, 32'h7777_0000, 31'd5);
        random_items(60);
        write_cap(7'd1);
        random_items(40);
        write_cap(7'd64);
    endtask

    task automatic test_random_phases();
        send_idle_pct = 0;  recv_stall_pct = 0;  random_items(150);
        send_idle_pct = 58; recv_stall_pct = 0;  random_items(120);
        send_idle_pct = 0;  recv_stall_pct = 58; random_items(120);
        send_idle_pct = 7;  recv_stall_pct = 7;  random_items(120);
        send_idle_pct = 0;  recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_off = 600;
        random_items(10);
        write_cap(7'd16);
        random_items(60);
    endtask

    initial begin
        table_reset();
        req_ch.valid = 1'b0; req_ch.cmd = lfu_pkg::CMD_GET; req_ch.key = '0;
        req_ch.value = '0;
        cfg_ch.valid = 1'b0; cfg_ch.data = '0;
        rsp_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_small_capacity();
        test_zero_capacity();
        test_capacity_extremes();
        test_random_phases();
        test_backpressure();
        drain();
        if (mismatches == 0 && expected_rsp.size() == 0) begin
            $display("tb_lfu_cache_table_core OK");
        end else begin
            $display("tb_lfu_cache_table_core NOT OK");
        end
        $finish;
    end
endmodule
